>>> hw/rtl/cce_pkg.sv
// Cube coordinate encoder package: port layout, field widths and weight tables.
// Stand-alone; used by cube_coordinate_encoder.
package cce_pkg;

   // request tdata layout, lowest bit first
   localparam int CL_LSB     = 0;    // corner_labels, 8 x 3 bits
   localparam int CT_LSB     = 24;   // corner_twists, 8 x 2 bits
   localparam int EL_LSB     = 40;   // edge_labels, 12 x 4 bits
   localparam int EF_LSB     = 88;   // edge_flips, 12 x 1 bit
   localparam int REQ_DATA_W = 104;

   // response tdata layout, lowest bit first
   localparam int RSP_DATA_W = 96;

   localparam int N_CORNER  = 8;
   localparam int N_EDGE    = 12;
   localparam int N_TRACK   = 6;
   localparam int N_TWIST   = 7;
   localparam int N_FLIP    = 11;

   localparam int CRANK_W = 16;
   localparam int ERANK_W = 29;
   localparam int TWIST_W = 12;
   localparam int FLIP_W  = 11;
   localparam int PRANK_W = 20;
   localparam int GROUP_W = 26;

   localparam logic [3:0] EDGE_LABEL_LIMIT = 4'd12;
   localparam logic [1:0] TWIST_WRAP       = 2'd3;

   typedef logic [2:0] corner_label_type;
   typedef logic [3:0] edge_label_type;

   // factorial-base weights of each Lehmer digit
   localparam logic [CRANK_W-1:0] CORNER_FACT [N_CORNER] = '{
      16'd5040, 16'd720, 16'd120, 16'd24, 16'd6, 16'd2, 16'd1, 16'd1
   };
   localparam logic [ERANK_W-1:0] EDGE_FACT [N_EDGE] = '{
      29'd39916800, 29'd3628800, 29'd362880, 29'd40320, 29'd5040, 29'd720,
      29'd120, 29'd24, 29'd6, 29'd2, 29'd1, 29'd1
   };
   // falling-factorial weights of the partial position rank, P(12,6)
   localparam logic [PRANK_W-1:0] PARTIAL_FACT [N_TRACK] = '{
      20'd55440, 20'd5040, 20'd504, 20'd56, 20'd7, 20'd1
   };
   // base-3 weights, slot 0 most significant
   localparam logic [TWIST_W-1:0] TWIST_WEIGHT [N_TWIST] = '{
      12'd729, 12'd243, 12'd81, 12'd27, 12'd9, 12'd3, 12'd1
   };

endpackage

>>> hw/rtl/cube_coordinate_encoder.sv
// Cube coordinate encoder top level: four-stage pipeline from cube state to
// pruning-table coordinates. Depends on cce_pkg.

// Takes one packed cube state per item and returns one item of coordinates:
// corner and edge permutation Lehmer ranks, the base-3 twist index of corners
// 0..6, the binary flip index of edges 0..10 (slot 0 most significant), and
// the tracked-edge group index (partial position rank times 64 plus the six
// tracked flips). A repeated corner or edge label, or an edge label of 12 or
// more, sets rsp_tuser and forces both permutation ranks and the group index
// to zero; twist and flip indices are still reported. The block holds no state
// between items. It accepts one item every cycle unless backpressure holds it,
// and passes it through four register stages (compare/count, constant products,
// partial sums, final sums into the output register). Backpressure on rsp_tready
// stalls only the stages that are full.
module cube_coordinate_encoder
   import cce_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // corner_labels, corner_twists, edge_labels, edge_flips, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // edge_group
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // corner_perm_rank, edge_perm_rank, corner_twist_index, edge_flip_index,
   // edge_group_index, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // state_invalid
   output logic                  rsp_tuser
);

   // stage valids and per-stage advance
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4       = !v4_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign rsp_tvalid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // ---------------- stage 1: unpack, compare, count ----------------
   corner_label_type cl [N_CORNER];
   edge_label_type   el [N_EDGE];
   logic [1:0]       ct [N_TWIST];
   logic [N_EDGE-1:0] ef;
   edge_label_type   track_label [N_TRACK];

   logic [2:0]        s1_cdig_in [N_CORNER];
   logic [3:0]        s1_edig_in [N_EDGE];
   logic [3:0]        s1_pos_in  [N_TRACK];
   logic [1:0]        s1_tdig_in [N_TWIST];
   logic [FLIP_W-1:0] s1_flip_in;
   logic [N_TRACK-1:0] s1_gflip_in;
   logic              s1_bad_in;

   logic [2:0]        s1_cdig_ff [N_CORNER];
   logic [3:0]        s1_edig_ff [N_EDGE];
   logic [3:0]        s1_pos_ff  [N_TRACK];
   logic [1:0]        s1_tdig_ff [N_TWIST];
   logic [FLIP_W-1:0] s1_flip_ff;
   logic [N_TRACK-1:0] s1_gflip_ff;
   logic              s1_bad_ff;

   // field unpack
   always_comb begin
      for (int i = 0; i < N_CORNER; i++) cl[i] = req_tdata[CL_LSB + 3*i +: 3];
      for (int i = 0; i < N_EDGE; i++)   el[i] = req_tdata[EL_LSB + 4*i +: 4];
      for (int i = 0; i < N_TWIST; i++)  ct[i] = req_tdata[CT_LSB + 2*i +: 2];
      ef = req_tdata[EF_LSB +: N_EDGE];
      for (int k = 0; k < N_TRACK; k++)
         track_label[k] = (req_tuser ? 4'd6 : 4'd0) + 4'(k);
   end

   // Lehmer digits: count smaller labels to the right
   always_comb begin
      for (int i = 0; i < N_CORNER; i++) begin
         s1_cdig_in[i] = 3'd0;
         for (int j = 0; j < N_CORNER; j++)
            if (j > i && cl[j] < cl[i]) s1_cdig_in[i] = s1_cdig_in[i] + 3'd1;
      end
      for (int i = 0; i < N_EDGE; i++) begin
         s1_edig_in[i] = 4'd0;
         for (int j = 0; j < N_EDGE; j++)
            if (j > i && el[j] < el[i]) s1_edig_in[i] = s1_edig_in[i] + 4'd1;
      end
   end

   // label check: any repeat, or an edge label out of range
   always_comb begin
      s1_bad_in = 1'b0;
      for (int i = 0; i < N_CORNER; i++)
         for (int j = 0; j < N_CORNER; j++)
            if (j > i && cl[j] == cl[i]) s1_bad_in = 1'b1;
      for (int i = 0; i < N_EDGE; i++) begin
         if (el[i] >= EDGE_LABEL_LIMIT) s1_bad_in = 1'b1;
         for (int j = 0; j < N_EDGE; j++)
            if (j > i && el[j] == el[i]) s1_bad_in = 1'b1;
      end
   end

   // slot of each tracked label and its flip; unique when labels are valid
   always_comb begin
      for (int k = 0; k < N_TRACK; k++) begin
         s1_pos_in[k]   = 4'd0;
         s1_gflip_in[k] = 1'b0;
         for (int i = 0; i < N_EDGE; i++)
            if (el[i] == track_label[k]) begin
               s1_pos_in[k]   = s1_pos_in[k] | 4'(i);
               s1_gflip_in[k] = s1_gflip_in[k] | ef[i];
            end
      end
   end

   // twist digits mod 3, flip index bit-reversed
   always_comb begin
      for (int i = 0; i < N_TWIST; i++)
         s1_tdig_in[i] = (ct[i] == TWIST_WRAP) ? 2'd0 : ct[i];
      for (int i = 0; i < N_FLIP; i++)
         s1_flip_in[N_FLIP-1-i] = ef[i];
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_cdig_ff  <= s1_cdig_in;
         s1_edig_ff  <= s1_edig_in;
         s1_pos_ff   <= s1_pos_in;
         s1_tdig_ff  <= s1_tdig_in;
         s1_flip_ff  <= s1_flip_in;
         s1_gflip_ff <= s1_gflip_in;
         s1_bad_ff   <= s1_bad_in;
      end
   end

   // ---------------- stage 2: digit weights ----------------
   logic [CRANK_W-1:0] s2_cprod_in [N_CORNER];
   logic [ERANK_W-1:0] s2_eprod_in [N_EDGE];
   logic [3:0]         s2_pc_in    [N_TRACK];
   logic [3:0]         lower_cnt   [N_TRACK];
   logic [TWIST_W-1:0] s2_tw_in;

   logic [CRANK_W-1:0] s2_cprod_ff [N_CORNER];
   logic [ERANK_W-1:0] s2_eprod_ff [N_EDGE];
   logic [3:0]         s2_pc_ff    [N_TRACK];
   logic [TWIST_W-1:0] s2_tw_ff;
   logic [FLIP_W-1:0]  s2_flip_ff;
   logic [N_TRACK-1:0] s2_gflip_ff;
   logic               s2_bad_ff;

   always_comb begin
      for (int i = 0; i < N_CORNER; i++)
         s2_cprod_in[i] = {13'd0, s1_cdig_ff[i]} * CORNER_FACT[i];
      for (int i = 0; i < N_EDGE; i++)
         s2_eprod_in[i] = {25'd0, s1_edig_ff[i]} * EDGE_FACT[i];
   end

   // partial digit: free slots below pos = pos minus earlier tracked slots below it
   always_comb begin
      for (int k = 0; k < N_TRACK; k++) begin
         lower_cnt[k] = 4'd0;
         for (int m = 0; m < N_TRACK; m++)
            if (m < k && s1_pos_ff[m] < s1_pos_ff[k]) lower_cnt[k] = lower_cnt[k] + 4'd1;
         s2_pc_in[k] = s1_pos_ff[k] - lower_cnt[k];
      end
   end

   // base-3 twist index
   always_comb begin
      s2_tw_in = '0;
      for (int i = 0; i < N_TWIST; i++)
         s2_tw_in = s2_tw_in + {10'd0, s1_tdig_ff[i]} * TWIST_WEIGHT[i];
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_cprod_ff <= s2_cprod_in;
         s2_eprod_ff <= s2_eprod_in;
         s2_pc_ff    <= s2_pc_in;
         s2_tw_ff    <= s2_tw_in;
         s2_flip_ff  <= s1_flip_ff;
         s2_gflip_ff <= s1_gflip_ff;
         s2_bad_ff   <= s1_bad_ff;
      end
   end

   // ---------------- stage 3: partial sums ----------------
   logic [CRANK_W-1:0] s3_csum_in;
   logic [ERANK_W-1:0] s3_esum_in  [3];
   logic [PRANK_W-1:0] s3_pprod_in [N_TRACK];

   logic [CRANK_W-1:0] s3_csum_ff;
   logic [ERANK_W-1:0] s3_esum_ff  [3];
   logic [PRANK_W-1:0] s3_pprod_ff [N_TRACK];
   logic [TWIST_W-1:0] s3_tw_ff;
   logic [FLIP_W-1:0]  s3_flip_ff;
   logic [N_TRACK-1:0] s3_gflip_ff;
   logic               s3_bad_ff;

   always_comb begin
      s3_csum_in = '0;
      for (int i = 0; i < N_CORNER; i++) s3_csum_in = s3_csum_in + s2_cprod_ff[i];
      // edge rank in three groups of four
      for (int g = 0; g < 3; g++) begin
         s3_esum_in[g] = '0;
         for (int i = 0; i < 4; i++)
            s3_esum_in[g] = s3_esum_in[g] + s2_eprod_ff[4*g + i];
      end
      for (int k = 0; k < N_TRACK; k++)
         s3_pprod_in[k] = {16'd0, s2_pc_ff[k]} * PARTIAL_FACT[k];
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_csum_ff  <= s3_csum_in;
         s3_esum_ff  <= s3_esum_in;
         s3_pprod_ff <= s3_pprod_in;
         s3_tw_ff    <= s2_tw_ff;
         s3_flip_ff  <= s2_flip_ff;
         s3_gflip_ff <= s2_gflip_ff;
         s3_bad_ff   <= s2_bad_ff;
      end
   end

   // ---------------- stage 4: final sums into output register ----------------
   logic [ERANK_W-1:0] erank_sum;
   logic [PRANK_W-1:0] prank_sum;
   logic [CRANK_W-1:0] s4_crank_in;
   logic [ERANK_W-1:0] s4_erank_in;
   logic [GROUP_W-1:0] s4_group_in;

   logic [CRANK_W-1:0] s4_crank_ff;
   logic [ERANK_W-1:0] s4_erank_ff;
   logic [GROUP_W-1:0] s4_group_ff;
   logic [TWIST_W-1:0] s4_tw_ff;
   logic [FLIP_W-1:0]  s4_flip_ff;
   logic               s4_bad_ff;

   always_comb begin
      erank_sum = s3_esum_ff[0] + s3_esum_ff[1] + s3_esum_ff[2];
      prank_sum = '0;
      for (int k = 0; k < N_TRACK; k++) prank_sum = prank_sum + s3_pprod_ff[k];
      // invalid labels zero the ranks
      s4_crank_in = s3_bad_ff ? '0 : s3_csum_ff;
      s4_erank_in = s3_bad_ff ? '0 : erank_sum;
      s4_group_in = s3_bad_ff ? '0 : {prank_sum, s3_gflip_ff};
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_crank_ff <= s4_crank_in;
         s4_erank_ff <= s4_erank_in;
         s4_group_ff <= s4_group_in;
         s4_tw_ff    <= s3_tw_ff;
         s4_flip_ff  <= s3_flip_ff;
         s4_bad_ff   <= s3_bad_ff;
      end
   end

   assign rsp_tdata = {2'b00, s4_group_ff, s4_flip_ff, s4_tw_ff, s4_erank_ff, s4_crank_ff};
   assign rsp_tuser = s4_bad_ff;

endmodule
